### sv/clb_pkg.sv
// Shared types and codes for the cursor list buffer.
package clb_pkg;

    // Operation codes carried by each input transaction
    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_REPLACE = 3'd2,
        OP_BEGIN   = 3'd3,
        OP_END     = 3'd4,
        OP_NEXT    = 3'd5,
        OP_PRIOR   = 3'd6,
        OP_CLEAR   = 3'd7
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE,
        ST_FILL,
        ST_LOOK,
        ST_RESP
    } state_t;

    localparam int CAP_W   = 5;
    localparam int ITEM_W  = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    typedef struct packed {
        op_t                op;
        logic [ITEM_W-1:0]  item_value;
    } clb_in_t;

    typedef struct packed {
        logic [ITEM_W-1:0]  cursor_item;
        logic [INDEX_W-1:0] cursor_index;
        logic [COUNT_W-1:0] item_count;
        logic               empty_flag;
        logic               full_flag;
        logic               refused;
    } clb_out_t;

endpackage

### sv/clb_mem.sv
// Entry store: one write port, one read port with registered read data.
module clb_mem
    import clb_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0]        wr_data,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0]        rd_data
);

    logic [DATA_WIDTH-1:0] entries_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= entries_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/clb_ctrl.sv
// Sequencer: decodes operations, shifts entries through the memory, builds results.
module clb_ctrl
    import clb_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  clb_in_t                      in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output clb_out_t                     out_data,
    input  logic                         cfg_we,
    input  logic [CAP_W-1:0]             cfg_wdata,
    output logic                         mem_we,
    output logic [$clog2(DEPTH)-1:0]     mem_wr_addr,
    output logic [DATA_WIDTH-1:0]        mem_wr_data,
    output logic                         mem_re,
    output logic [$clog2(DEPTH)-1:0]     mem_rd_addr,
    input  logic [DATA_WIDTH-1:0]        mem_rd_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    state_t                state_reg, state_next;
    logic [CAP_W-1:0]      capacity_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         cursor_reg, cursor_next;
    logic [AW-1:0]         src_reg, src_next;
    logic [AW-1:0]         dst_reg, dst_next;
    logic [CW-1:0]         moves_reg, moves_next;
    logic                  pend_reg, pend_next;
    logic                  down_reg, down_next;
    logic                  fill_reg, fill_next;
    logic                  refused_reg, refused_next;
    logic [DATA_WIDTH-1:0] val_reg;
    logic                  out_valid_reg, out_valid_next;
    clb_out_t              out_data_reg;

    logic                  accept;
    logic                  load_out;
    logic [CMPW-1:0]       cap_eff;
    logic                  full;
    logic [CW-1:0]         cur_plus1;
    logic [AW-1:0]         last_idx;
    logic [AW-1:0]         ins_pos;
    logic [CW-1:0]         rem_count;

    // Effective capacity and full test
    always_comb
    begin
        if (CMPW'(capacity_reg) > CMPW'(DEPTH))
        begin
            cap_eff = CMPW'(DEPTH);
        end
        else
        begin
            cap_eff = CMPW'(capacity_reg);
        end
        full      = (CMPW'(count_reg) >= cap_eff);
        cur_plus1 = CW'(cursor_reg) + CW'(1);
        last_idx  = AW'(count_reg - CW'(1));
        ins_pos   = (count_reg == '0) ? '0 : AW'(cur_plus1);
        rem_count = count_reg - CW'(1);
    end

    assign accept = in_valid && (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (moves_next != '0)
                        state_next = ST_MOVE;
                    else if (fill_next)
                        state_next = ST_FILL;
                    else if (count_next != '0)
                        state_next = ST_LOOK;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_MOVE:
            begin
                if (moves_reg == '0 && pend_reg)
                begin
                    if (fill_reg)
                        state_next = ST_FILL;
                    else
                        state_next = ST_LOOK;
                end
            end
            ST_FILL: state_next = ST_LOOK;
            ST_LOOK: state_next = ST_RESP;
            ST_RESP:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake and memory controls
    always_comb
    begin
        in_stall    = 1'b1;
        mem_we      = 1'b0;
        mem_wr_addr = dst_reg;
        mem_wr_data = mem_rd_data;
        mem_re      = 1'b0;
        mem_rd_addr = src_reg;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_MOVE:
            begin
                mem_re = (moves_reg != '0);
                mem_we = pend_reg;
            end
            ST_FILL:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = cursor_reg;
                mem_wr_data = val_reg;
            end
            ST_LOOK:
            begin
                mem_re      = 1'b1;
                mem_rd_addr = cursor_reg;
            end
            ST_RESP:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Operation decode and shift bookkeeping
    always_comb
    begin
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        moves_next   = '0;
        pend_next    = 1'b0;
        down_next    = down_reg;
        fill_next    = fill_reg;
        refused_next = refused_reg;
        case (state_reg)
            ST_IDLE:
            begin
                fill_next    = 1'b0;
                refused_next = 1'b0;
                down_next    = 1'b0;
                if (accept)
                begin
                    case (in_data.op)
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                refused_next = 1'b1;
                            end
                            else
                            begin
                                moves_next  = count_reg - CW'(ins_pos);
                                src_next    = last_idx;
                                down_next   = 1'b1;
                                fill_next   = 1'b1;
                                cursor_next = ins_pos;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                refused_next = 1'b1;
                            end
                            else
                            begin
                                moves_next = rem_count - CW'(cursor_reg);
                                src_next   = AW'(cur_plus1);
                                count_next = rem_count;
                                if (CW'(cursor_reg) >= rem_count)
                                begin
                                    cursor_next = (rem_count == '0) ? '0
                                                  : AW'(rem_count - CW'(1));
                                end
                            end
                        end
                        OP_REPLACE:
                        begin
                            if (count_reg == '0)
                                refused_next = 1'b1;
                            else
                                fill_next = 1'b1;
                        end
                        OP_BEGIN:
                        begin
                            cursor_next = '0;
                        end
                        OP_END:
                        begin
                            cursor_next = (count_reg == '0) ? '0 : last_idx;
                        end
                        OP_NEXT:
                        begin
                            if (count_reg == '0 || cur_plus1 >= count_reg)
                                refused_next = 1'b1;
                            else
                                cursor_next = AW'(cur_plus1);
                        end
                        OP_PRIOR:
                        begin
                            if (count_reg == '0 || cursor_reg == '0)
                                refused_next = 1'b1;
                            else
                                cursor_next = cursor_reg - AW'(1);
                        end
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        default:
                        begin
                            refused_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_MOVE:
            begin
                // read one source per cycle, write the previous one behind it
                moves_next = moves_reg;
                if (moves_reg != '0)
                begin
                    src_next   = down_reg ? src_reg - AW'(1) : src_reg + AW'(1);
                    dst_next   = down_reg ? src_reg + AW'(1) : src_reg - AW'(1);
                    moves_next = moves_reg - CW'(1);
                    pend_next  = 1'b1;
                end
            end
            default:
            begin
                moves_next = '0;
            end
        endcase
    end

    // Output register
    assign out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_W'(16);
            count_reg     <= '0;
            cursor_reg    <= '0;
            moves_reg     <= '0;
            pend_reg      <= 1'b0;
            down_reg      <= 1'b0;
            fill_reg      <= 1'b0;
            refused_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            moves_reg     <= moves_next;
            pend_reg      <= pend_next;
            down_reg      <= down_next;
            fill_reg      <= fill_next;
            refused_reg   <= refused_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        dst_reg <= dst_next;
        if (accept)
        begin
            val_reg <= DATA_WIDTH'(in_data.item_value);
        end
        if (load_out)
        begin
            out_data_reg.cursor_item  <= (count_reg == '0) ? '0 : ITEM_W'(mem_rd_data);
            out_data_reg.cursor_index <= (count_reg == '0) ? '0 : INDEX_W'(cursor_reg);
            out_data_reg.item_count   <= COUNT_W'(count_reg);
            out_data_reg.empty_flag   <= (count_reg == '0);
            out_data_reg.full_flag    <= full;
            out_data_reg.refused      <= refused_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### sv/cursor_list_buffer_top.sv
// Top level of the cursor list buffer: sequencer plus entry memory.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  in_data  (clb_in_t)
//  out       output     out_valid/out_stall  out_data (clb_out_t)
//  cfg       input      cfg_we               cfg_wdata (capacity)
//
// One transaction at a time. After acceptance the sequencer shifts entries (MOVE,
// insert and remove), writes the new item (FILL, insert and replace), reads the
// cursor entry (LOOK, when the list is not empty) and loads the result (RESP).
// An insert shifts n entries, n up to DEPTH - 2, and a remove n up to DEPTH - 1,
// one entry per cycle through the single memory read port; then back to IDLE.
// The result sits in an output register, so a new transaction is accepted while
// it waits under out_stall. Reset clears count, cursor and capacity (to 16);
// entry contents are not cleared.
module cursor_list_buffer_top
    import clb_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  clb_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output clb_out_t         out_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(DEPTH);

    logic                  mem_we;
    logic [AW-1:0]         mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic                  mem_re;
    logic [AW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_rd_data;

    clb_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mem_we      (mem_we),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_re      (mem_re),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    clb_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .re      (mem_re),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

### sv/clb_checker.sv
// Port-level assertions for the cursor list buffer, bound to the top level.
module clb_checker
    import clb_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input clb_out_t         out_data
);

    // A held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One transaction in flight: stall rises right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while busy");

    // Empty flag agrees with the count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.empty_flag == (out_data.item_count == '0)))
        else $error("empty flag mismatch");

    // Empty list reports a zero cursor and item
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.empty_flag |->
            (out_data.cursor_index == '0) && (out_data.cursor_item == '0))
        else $error("nonzero cursor on empty list");

    // Cursor stays inside the list
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.empty_flag && (out_data.item_count <= 5'd16) |->
            (COUNT_W'(out_data.cursor_index) < out_data.item_count))
        else $error("cursor beyond count");

endmodule

bind cursor_list_buffer_top clb_checker u_clb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

### tb/sv/testbench.sv
// Self-checking testbench for the cursor list buffer: directed table, then random phases.
`timescale 1ns / 1ps

module testbench
    import clb_pkg::*;
();

    localparam int DEPTH = 16;

    // Opening table row: operation, item, and a hand-written report where one is given
    typedef struct {
        op_t         op;
        logic [31:0] value;
        bit          typed;
        clb_out_t    report;
    } step_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    clb_in_t          in_data;
    logic             out_valid;
    logic             out_stall;
    clb_out_t         out_data;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    // Mirror of the list as the block should hold it
    logic [31:0] list_mem [DEPTH];
    int          list_count;
    int          list_cursor;
    int          list_cap;

    clb_out_t    cursor_reports [$];
    clb_out_t    next_report;
    int          fail_count;
    bit          calm;
    bit          hold_req;
    step_row_t   opening_rows [22];

    cursor_list_buffer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Apply one operation to the mirror and return the report it should produce
    function automatic clb_out_t apply_list_op(input clb_in_t t);
        clb_out_t r;
        int       lim;
        int       pos;
        int       i;
        bit       no;
        lim = (list_cap > DEPTH) ? DEPTH : list_cap;
        no = 1'b0;
        case (t.op)
            OP_INSERT:
            begin
                if (list_count >= lim)
                    no = 1'b1;
                else
                begin
                    pos = (list_count == 0) ? 0 : list_cursor + 1;
                    for (i = list_count; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = t.item_value;
                    list_cursor = pos;
                    list_count++;
                end
            end
            OP_REMOVE:
            begin
                if (list_count == 0)
                    no = 1'b1;
                else
                begin
                    for (i = list_cursor; i + 1 < list_count; i++)
                        list_mem[i] = list_mem[i+1];
                    list_count--;
                    // removed the tail: fall back to the new last item
                    if (list_cursor >= list_count)
                        list_cursor = (list_count == 0) ? 0 : list_count - 1;
                end
            end
            OP_REPLACE:
            begin
                if (list_count == 0)
                    no = 1'b1;
                else
                    list_mem[list_cursor] = t.item_value;
            end
            OP_BEGIN:
                list_cursor = 0;
            OP_END:
                list_cursor = (list_count == 0) ? 0 : list_count - 1;
            OP_NEXT:
            begin
                if (list_count == 0 || list_cursor + 1 >= list_count)
                    no = 1'b1;
                else
                    list_cursor++;
            end
            OP_PRIOR:
            begin
                if (list_count == 0 || list_cursor == 0)
                    no = 1'b1;
                else
                    list_cursor--;
            end
            default:
            begin
                list_count = 0;
                list_cursor = 0;
            end
        endcase
        r.cursor_item  = (list_count == 0) ? 32'h0 : list_mem[list_cursor];
        r.cursor_index = (list_count == 0) ? 4'd0 : 4'(list_cursor);
        r.item_count   = 5'(list_count);
        r.empty_flag   = (list_count == 0);
        r.full_flag    = (list_count >= lim);
        r.refused      = no;
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic op_t pick_op(input int ins_pct);
        if ($urandom_range(0, 99) < ins_pct)
            return OP_INSERT;
        if ($urandom_range(0, 99) < 3)
            return OP_CLEAR;
        return op_t'($urandom_range(1, 6));
    endfunction

    // Offer one transaction; returns once it has been accepted
    task automatic send_op(input clb_in_t t, input bit typed, input clb_out_t typed_rep);
        int       gap;
        clb_out_t want;
        gap = calm ? 0 : idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = apply_list_op(t);
        cursor_reports = {cursor_reports, (typed ? typed_rep : want)};
    endtask

    // Drop valid and wait until every pending report has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (cursor_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input int cap);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CAP_W'(cap);
        list_cap = cap;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_report(input clb_out_t want, input clb_out_t got);
        if (got.cursor_item !== want.cursor_item)
        begin
            $error("cursor_item: expected %0h, got %0h", want.cursor_item, got.cursor_item);
            fail_count++;
        end
        if (got.cursor_index !== want.cursor_index)
        begin
            $error("cursor_index: expected %0d, got %0d", want.cursor_index, got.cursor_index);
            fail_count++;
        end
        if (got.item_count !== want.item_count)
        begin
            $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
            fail_count++;
        end
        if (got.empty_flag !== want.empty_flag)
        begin
            $error("empty_flag: expected %0b, got %0b", want.empty_flag, got.empty_flag);
            fail_count++;
        end
        if (got.full_flag !== want.full_flag)
        begin
            $error("full_flag: expected %0b, got %0b", want.full_flag, got.full_flag);
            fail_count++;
        end
        if (got.refused !== want.refused)
        begin
            $error("refused: expected %0b, got %0b", want.refused, got.refused);
            fail_count++;
        end
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (cursor_reports.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end
            else
            begin
                next_report = cursor_reports.pop_front();
                check_report(next_report, out_data);
            end
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off on request
    initial
    begin
        int stall_left;
        out_stall = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = calm ? 0 : idle_len();
            end
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("cursor_list_buffer_top verification failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        int       caps [9];
        int       p;
        int       n;
        clb_in_t  t;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        fail_count = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        list_count  = 0;
        list_cursor = 0;
        list_cap    = 16;
        for (n = 0; n < DEPTH; n++)
            list_mem[n] = '0;
        caps = '{16, 3, 1, 0, 31, 17, 8, 2, 16};

        // report fields: item, index, count, empty, full, refused
        opening_rows = '{
            '{OP_NEXT,    32'h0,         1'b1, '{32'h0, 4'd0, 5'd0, 1'b1, 1'b0, 1'b1}},
            '{OP_PRIOR,   32'h0,         1'b1, '{32'h0, 4'd0, 5'd0, 1'b1, 1'b0, 1'b1}},
            '{OP_REMOVE,  32'h0,         1'b1, '{32'h0, 4'd0, 5'd0, 1'b1, 1'b0, 1'b1}},
            '{OP_REPLACE, 32'hFFFF_FFFF, 1'b1, '{32'h0, 4'd0, 5'd0, 1'b1, 1'b0, 1'b1}},
            '{OP_BEGIN,   32'hFFFF_FFFF, 1'b1, '{32'h0, 4'd0, 5'd0, 1'b1, 1'b0, 1'b0}},
            '{OP_END,     32'h0,         1'b1, '{32'h0, 4'd0, 5'd0, 1'b1, 1'b0, 1'b0}},
            '{OP_CLEAR,   32'h0,         1'b1, '{32'h0, 4'd0, 5'd0, 1'b1, 1'b0, 1'b0}},
            '{OP_INSERT,  32'hFFFF_FFFF, 1'b1,
              '{32'hFFFF_FFFF, 4'd0, 5'd1, 1'b0, 1'b0, 1'b0}},
            '{OP_INSERT,  32'h0,         1'b1, '{32'h0, 4'd1, 5'd2, 1'b0, 1'b0, 1'b0}},
            '{OP_PRIOR,   32'h0,         1'b1,
              '{32'hFFFF_FFFF, 4'd0, 5'd2, 1'b0, 1'b0, 1'b0}},
            // prior at the first item
            '{OP_PRIOR,   32'h0,         1'b1,
              '{32'hFFFF_FFFF, 4'd0, 5'd2, 1'b0, 1'b0, 1'b1}},
            // insert in the middle shifts the tail right
            '{OP_INSERT,  32'hA5A5_5A5A, 1'b1,
              '{32'hA5A5_5A5A, 4'd1, 5'd3, 1'b0, 1'b0, 1'b0}},
            '{OP_END,     32'h0,         1'b1, '{32'h0, 4'd2, 5'd3, 1'b0, 1'b0, 1'b0}},
            // next at the last item
            '{OP_NEXT,    32'h0,         1'b1, '{32'h0, 4'd2, 5'd3, 1'b0, 1'b0, 1'b1}},
            // remove the tail: cursor falls back to the new last item
            '{OP_REMOVE,  32'h0,         1'b1,
              '{32'hA5A5_5A5A, 4'd1, 5'd2, 1'b0, 1'b0, 1'b0}},
            '{OP_BEGIN,   32'h0,         1'b1,
              '{32'hFFFF_FFFF, 4'd0, 5'd2, 1'b0, 1'b0, 1'b0}},
            // remove the head: cursor rests on the following item
            '{OP_REMOVE,  32'h0,         1'b1,
              '{32'hA5A5_5A5A, 4'd0, 5'd1, 1'b0, 1'b0, 1'b0}},
            '{OP_REPLACE, 32'h8000_0001, 1'b0, '0},
            '{OP_INSERT,  32'h7FFF_FFFE, 1'b0, '0},
            '{OP_NEXT,    32'h0,         1'b0, '0},
            '{OP_CLEAR,   32'hFFFF_FFFF, 1'b1, '{32'h0, 4'd0, 5'd0, 1'b1, 1'b0, 1'b0}},
            // after clear, insert lands at index 0 over stale entries
            '{OP_INSERT,  32'h1234_5678, 1'b1,
              '{32'h1234_5678, 4'd0, 5'd1, 1'b0, 1'b0, 1'b0}}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (opening_rows[k])
        begin
            t.op = opening_rows[k].op;
            t.item_value = opening_rows[k].value;
            send_op(t, opening_rows[k].typed, opening_rows[k].report);
        end

        // Random phases, one capacity setting each; state carries across phases
        for (p = 0; p < 9; p++)
        begin
            write_capacity(caps[p]);
            calm = (p == 2 || p == 6);
            if (p == 1)
                hold_req = 1'b1;
            for (n = 0; n < 67; n++)
            begin
                t.op = pick_op((caps[p] >= 16) ? 50 : 28);
                t.item_value = $urandom();
                send_op(t, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (25) @(negedge clk);
        if (fail_count == 0)
            $display("cursor_list_buffer_top verification clean");
        else
            $display("cursor_list_buffer_top verification failed");
        $finish;
    end

endmodule
